>>> design/sde_pkg.sv
// Shared types and constants of the shuffle draw engine.
package sde_pkg;

  localparam int RAND_W     = 31;
  localparam int BALL_W     = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int POOL_W     = 8;
  localparam int PICK_W     = 4;
  localparam int LIMIT_W    = 8;
  localparam int DIV_CNT_W  = $clog2(RAND_W);

  localparam logic [CFG_IDX_W-1:0] CFG_POOL_SIZE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PICK_COUNT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPECIAL_LIMIT = 2'd2;

  localparam int POOL_RESET = 69;
  localparam int PICK_RESET = 6;
  localparam int LIMIT_RESET = 10;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_RD_SEL,
    ST_WR_IDX,
    ST_WR_SEL,
    ST_LOAD,
    ST_SEARCH,
    ST_EMIT
  } state_e;

endpackage

>>> design/sde_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module sde_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/shuffle_draw_engine.sv
// Shuffle draw engine: one Fisher-Yates swap per random word, sorted picks and a special number
// at the end of each draw.
//
// Each accepted random word goes through the bit-serial remainder unit that reduces the word
// modulo the step index plus one, then through the read of the chosen entry and the two
// write-backs of the swap, all through the single read and single write port of the
// permutation table RAM. No result follows until the swap at index 1; that item then also
// reads the first pick-count entries into a row of sorting lanes (one entry a cycle), scans
// the later entries one a cycle until the first one at or below the special limit or the end
// of the pool, and emits pick-count sorted numbers followed by the special number, one per
// output transfer, writing the sorted numbers back into the table as they leave. A new random
// word is taken only after the last result of the previous one has been transferred. The
// table starts as the identity right after reset and after every pool size write, with no
// clearing pass: a per-entry valid flag marks entries written since then.
module shuffle_draw_engine #(
  parameter int MAX_POOL = 128,
  parameter int MAX_PICK = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [sde_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [sde_pkg::CFG_DATA_W-1:0]   cfg_wdata_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [sde_pkg::RAND_W-1:0]       random_word_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [sde_pkg::BALL_W-1:0]       ball_number_o,
  output logic                             is_special_o,
  output logic                             last_o
);

  localparam int IW  = $clog2(MAX_POOL);
  localparam int PW  = $clog2(MAX_POOL + 1);
  localparam int VW  = $clog2(MAX_POOL + 1);
  localparam int PKW = $clog2(MAX_PICK + 1);
  localparam int LW  = (MAX_PICK > 1) ? $clog2(MAX_PICK) : 1;
  localparam int PoolRst = (sde_pkg::POOL_RESET < 2) ? 2 :
                           ((sde_pkg::POOL_RESET > MAX_POOL) ? MAX_POOL : sde_pkg::POOL_RESET);

  function automatic logic [PW-1:0] eff_pool(input logic [sde_pkg::POOL_W-1:0] v);
    logic [PW-1:0] r;
    if (int'(v) < 2) begin
      r = PW'(2);
    end else if (int'(v) > MAX_POOL) begin
      r = PW'(MAX_POOL);
    end else begin
      r = PW'(v);
    end
    return r;
  endfunction

  sde_pkg::state_e state_q, state_d;

  logic [sde_pkg::POOL_W-1:0]  pool_q;
  logic [sde_pkg::PICK_W-1:0]  pick_q;
  logic [sde_pkg::LIMIT_W-1:0] limit_q;
  logic [IW-1:0]               step_q, step_d;
  logic [MAX_POOL-1:0]         valid_q, valid_d;
  logic [sde_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [PW-1:0]               scan_q, scan_d;
  logic [PKW-1:0]              n_q, n_d;
  logic [PKW-1:0]              emit_q, emit_d;
  logic                        pend_q, pend_d;
  logic                        rd_valid_q;
  logic [IW-1:0]               rd_addr_q;

  logic [sde_pkg::RAND_W-1:0]  dvd_q, dvd_d;
  logic [IW-1:0]               rem_q, rem_d;
  logic [PW-1:0]               dsr_q, dsr_d;
  logic [IW-1:0]               idx_q, idx_d;
  logic [VW-1:0]               a_q, a_d;
  logic [VW-1:0]               sorted_q [MAX_PICK];
  logic [VW-1:0]               sorted_d [MAX_PICK];
  logic [VW-1:0]               special_q, special_d;

  logic [PW-1:0]               pool_eff;
  logic [PKW-1:0]              picks;
  logic [IW-1:0]               idx_now;
  logic [IW:0]                 div_try;
  logic                        in_xfer;
  logic                        out_xfer;
  logic                        ram_we;
  logic [IW-1:0]               ram_waddr;
  logic [VW-1:0]               ram_wdata;
  logic                        ram_re;
  logic [IW-1:0]               ram_raddr;
  logic [VW-1:0]               ram_rdata;
  logic [VW-1:0]               rd_val;
  logic                        hit;
  logic [MAX_PICK-1:0]         gt;
  logic [VW-1:0]               ins [MAX_PICK];
  logic                        emit_pick;

  sde_ram #(
    .WIDTH(VW),
    .DEPTH(MAX_POOL)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Effective configuration and the clamped step index.
  always_comb begin
    int pc;
    pool_eff = eff_pool(pool_q);
    pc = int'(pick_q);
    if (pc < 1) begin
      pc = 1;
    end
    if (pc > MAX_PICK) begin
      pc = MAX_PICK;
    end
    if (pc > int'(pool_eff)) begin
      pc = int'(pool_eff);
    end
    picks = PKW'(pc);
    if (int'(step_q) >= int'(pool_eff) - 1) begin
      idx_now = IW'(pool_eff - PW'(1));
    end else if (step_q == '0) begin
      idx_now = IW'(1);
    end else begin
      idx_now = step_q;
    end
  end

  // An entry never written since the last identity load reads as its address plus one.
  assign rd_val = rd_valid_q ? ram_rdata : (VW'(rd_addr_q) + VW'(1));
  assign hit    = int'(rd_val) <= int'(limit_q);

  assign in_xfer   = in_valid_i && in_ready_o;
  assign out_xfer  = out_valid_o && out_ready_i;
  assign emit_pick = emit_q < picks;

  // Insertion of the returning entry into the ascending sorting lanes.
  always_comb begin
    for (int j = 0; j < MAX_PICK; j++) begin
      gt[j] = (j >= int'(n_q)) || (sorted_q[j] > rd_val);
    end
    ins[0] = gt[0] ? rd_val : sorted_q[0];
    for (int j = 1; j < MAX_PICK; j++) begin
      if (!gt[j]) begin
        ins[j] = sorted_q[j];
      end else if (!gt[j-1]) begin
        ins[j] = rd_val;
      end else begin
        ins[j] = sorted_q[j-1];
      end
    end
  end

  assign div_try = {rem_q, dvd_q[sde_pkg::RAND_W-1]};

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      sde_pkg::ST_IDLE: begin
        if (in_xfer) begin
          state_d = sde_pkg::ST_DIV;
        end
      end
      sde_pkg::ST_DIV: begin
        if (int'(cnt_q) == sde_pkg::RAND_W - 1) begin
          state_d = sde_pkg::ST_RD_SEL;
        end
      end
      sde_pkg::ST_RD_SEL: state_d = sde_pkg::ST_WR_IDX;
      sde_pkg::ST_WR_IDX: state_d = sde_pkg::ST_WR_SEL;
      sde_pkg::ST_WR_SEL: begin
        state_d = (idx_q == IW'(1)) ? sde_pkg::ST_LOAD : sde_pkg::ST_IDLE;
      end
      sde_pkg::ST_LOAD: begin
        if (!pend_q && int'(scan_q) >= int'(picks)) begin
          state_d = sde_pkg::ST_SEARCH;
        end
      end
      sde_pkg::ST_SEARCH: begin
        if ((pend_q && hit) || (!pend_q && scan_q >= pool_eff)) begin
          state_d = sde_pkg::ST_EMIT;
        end
      end
      sde_pkg::ST_EMIT: begin
        if (out_xfer && !emit_pick) begin
          state_d = sde_pkg::ST_IDLE;
        end
      end
      default: state_d = sde_pkg::ST_IDLE;
    endcase
  end

  // Datapath, memory accesses and outputs.
  always_comb begin
    step_d    = step_q;
    valid_d   = valid_q;
    cnt_d     = cnt_q;
    scan_d    = scan_q;
    n_d       = n_q;
    emit_d    = emit_q;
    pend_d    = pend_q;
    dvd_d     = dvd_q;
    rem_d     = rem_q;
    dsr_d     = dsr_q;
    idx_d     = idx_q;
    a_d       = a_q;
    special_d = special_q;
    for (int j = 0; j < MAX_PICK; j++) begin
      sorted_d[j] = sorted_q[j];
    end
    ram_we    = 1'b0;
    ram_waddr = idx_q;
    ram_wdata = rd_val;
    ram_re    = 1'b0;
    ram_raddr = idx_now;

    in_ready_o    = 1'b0;
    out_valid_o   = 1'b0;
    ball_number_o = '0;
    is_special_o  = 1'b0;
    last_o        = 1'b0;

    case (state_q)
      sde_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_xfer) begin
          // The entry at the step index is read while the remainder is worked out.
          ram_re = 1'b1;
          dvd_d  = random_word_i;
          rem_d  = '0;
          dsr_d  = PW'(idx_now) + PW'(1);
          idx_d  = idx_now;
          cnt_d  = '0;
        end
      end
      sde_pkg::ST_DIV: begin
        if (div_try >= (IW+1)'(dsr_q)) begin
          rem_d = IW'(div_try - (IW+1)'(dsr_q));
        end else begin
          rem_d = IW'(div_try);
        end
        dvd_d = {dvd_q[sde_pkg::RAND_W-2:0], 1'b0};
        cnt_d = cnt_q + sde_pkg::DIV_CNT_W'(1);
      end
      sde_pkg::ST_RD_SEL: begin
        a_d       = rd_val;
        ram_re    = 1'b1;
        ram_raddr = rem_q;
      end
      sde_pkg::ST_WR_IDX: begin
        ram_we    = 1'b1;
        ram_waddr = idx_q;
        ram_wdata = rd_val;
      end
      sde_pkg::ST_WR_SEL: begin
        ram_we    = 1'b1;
        ram_waddr = rem_q;
        ram_wdata = a_q;
        if (idx_q == IW'(1)) begin
          step_d    = IW'(pool_eff - PW'(1));
          scan_d    = '0;
          n_d       = '0;
          pend_d    = 1'b0;
          special_d = '0;
        end else begin
          step_d = idx_q - IW'(1);
        end
      end
      sde_pkg::ST_LOAD: begin
        if (pend_q) begin
          for (int j = 0; j < MAX_PICK; j++) begin
            sorted_d[j] = ins[j];
          end
          n_d = n_q + PKW'(1);
        end
        if (int'(scan_q) < int'(picks)) begin
          ram_re    = 1'b1;
          ram_raddr = IW'(scan_q);
          scan_d    = scan_q + PW'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end
      sde_pkg::ST_SEARCH: begin
        if (pend_q && hit) begin
          special_d = rd_val;
          pend_d    = 1'b0;
          emit_d    = '0;
        end else if (scan_q < pool_eff) begin
          ram_re    = 1'b1;
          ram_raddr = IW'(scan_q);
          scan_d    = scan_q + PW'(1);
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
          emit_d = '0;
        end
      end
      sde_pkg::ST_EMIT: begin
        out_valid_o = 1'b1;
        if (emit_pick) begin
          ball_number_o = sde_pkg::BALL_W'(sorted_q[emit_q[LW-1:0]]);
          if (out_xfer) begin
            // The sorted picks replace the head of the table as they leave.
            ram_we    = 1'b1;
            ram_waddr = IW'(emit_q);
            ram_wdata = sorted_q[emit_q[LW-1:0]];
            emit_d    = emit_q + PKW'(1);
          end
        end else begin
          ball_number_o = sde_pkg::BALL_W'(special_q);
          is_special_o  = 1'b1;
          last_o        = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (ram_we) begin
      valid_d[ram_waddr] = 1'b1;
    end

    // A pool size write reloads the identity table and restarts the shuffle.
    if (cfg_we_i && cfg_idx_i == sde_pkg::CFG_POOL_SIZE) begin
      valid_d = '0;
      step_d  = IW'(eff_pool(cfg_wdata_i) - PW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= sde_pkg::ST_IDLE;
      pool_q     <= sde_pkg::POOL_W'(sde_pkg::POOL_RESET);
      pick_q     <= sde_pkg::PICK_W'(sde_pkg::PICK_RESET);
      limit_q    <= sde_pkg::LIMIT_W'(sde_pkg::LIMIT_RESET);
      step_q     <= IW'(PoolRst - 1);
      valid_q    <= '0;
      cnt_q      <= '0;
      scan_q     <= '0;
      n_q        <= '0;
      emit_q     <= '0;
      pend_q     <= 1'b0;
      rd_valid_q <= 1'b0;
      rd_addr_q  <= '0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      scan_q  <= scan_d;
      n_q     <= n_d;
      emit_q  <= emit_d;
      pend_q  <= pend_d;
      if (ram_re) begin
        rd_valid_q <= valid_q[ram_raddr];
        rd_addr_q  <= ram_raddr;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          sde_pkg::CFG_POOL_SIZE:     pool_q  <= cfg_wdata_i;
          sde_pkg::CFG_PICK_COUNT:    pick_q  <= cfg_wdata_i[sde_pkg::PICK_W-1:0];
          sde_pkg::CFG_SPECIAL_LIMIT: limit_q <= cfg_wdata_i;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q     <= dvd_d;
    rem_q     <= rem_d;
    dsr_q     <= dsr_d;
    idx_q     <= idx_d;
    a_q       <= a_d;
    special_q <= special_d;
    for (int j = 0; j < MAX_PICK; j++) begin
      sorted_q[j] <= sorted_d[j];
    end
  end

endmodule
